// ----- design/assert_macros.svh -----
// Assertion macros shared by the calendar day number converter.
// Every macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge except while rst is high.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, during reset as well.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cdn_pkg.sv -----
// Shared types, constants and small functions of the calendar day number converter.
// Depends on nothing; every design file refers to it by scoped names.
package cdn_pkg;

  // Pipeline depth of the whole block and of the day-number-to-date path.
  localparam int unsigned STAGES       = 10;
  localparam int unsigned SPLIT_STAGES = 8;

  // Operation codes of a request.
  localparam logic OP_DATE_TO_JDN = 1'b0;
  localparam logic OP_JDN_TO_DATE = 1'b1;

  // Valid day number range (0001-01-01 Julian through 9999-12-31).
  localparam logic [22:0] JDN_MIN  = 23'd1721424;
  localparam logic [22:0] JDN_MAX  = 23'd5373484;
  // First day number of the Gregorian calendar (1582-10-15).
  localparam logic [22:0] GREG_JDN = 23'd2299161;
  // The same switch date as a {year, month, day} key.
  localparam logic [22:0] GREG_KEY = {14'd1582, 4'd10, 5'd15};

  // Reciprocal multipliers: floor(x / D) == (x * MUL) >> SHIFT holds exactly
  // for every x of the stated width because SHIFT >= width(x) + width(D).
  localparam int unsigned WK_SHIFT   = 27;  // x < 2^24, D = 7
  localparam logic [24:0] WK_MUL     = 25'(((64'd1 << WK_SHIFT) + 64'd6) / 64'd7);
  localparam int unsigned AL_SHIFT   = 43;  // x < 2^25, D = 146097
  localparam logic [25:0] AL_MUL     = 26'(((64'd1 << AL_SHIFT) + 64'd146096) / 64'd146097);
  localparam int unsigned C_SHIFT    = 46;  // x < 2^30, D = 36525
  localparam logic [30:0] C_MUL      = 31'(((64'd1 << C_SHIFT) + 64'd36524) / 64'd36525);
  localparam int unsigned HUND_SHIFT = 21;  // x < 2^14, D = 100
  localparam logic [14:0] HUND_MUL   = 15'(((64'd1 << HUND_SHIFT) + 64'd99) / 64'd100);

  // floor(30.6001 * k); for k in 1..15 this also equals floor(306 * k / 10).
  localparam logic [8:0] E_DAYS [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // floor(275 * m / 9) for months 1..12; other codes never reach a valid result.
  localparam logic [8:0] ORD_DAYS [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd213,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd366, 9'd0,   9'd0,   9'd0
  };

  // Days per month in a common year, indexed by month code.
  localparam logic [4:0] MONTH_DAYS [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  // One request item.
  typedef struct packed {
    logic        opcode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] day_number;
  } req_t;

  // One result item.
  typedef struct packed {
    logic        ok;
    logic [22:0] out_day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
  } rsp_t;

  // Fields that ride along the main pipeline.
  typedef struct packed {
    logic        op;
    logic        rng;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [22:0] jn;
    logic [2:0]  wd;
  } pipe_t;

  // Quotient of a year by 100.
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(HUND_MUL);
    return 8'(p >> HUND_SHIFT);
  endfunction

endpackage

// ----- design/cdn_jdn_to_date.sv -----
// Day number to civil date pipeline of the calendar day number converter.
// Eight register stages, each loaded by its own enable; uses cdn_pkg.
module cdn_jdn_to_date (
  input  logic                                 clk,
  input  logic [cdn_pkg::SPLIT_STAGES-1:0]     en,
  input  logic [22:0]                          day_number,
  output logic [4:0]                           day,
  output logic [3:0]                           month,
  output logic [13:0]                          year
);

  logic [22:0] jn1, jn2;
  logic        gr1, gr2;
  logic [24:0] xa1;
  logic [50:0] pa2;
  logic [7:0]  alpha;
  logic [22:0] b3, b4, b5;
  logic [29:0] xc4;
  logic [60:0] pc5;
  logic [14:0] c6, c7, c_cur;
  logic [25:0] dd6;
  logic [9:0]  rest6, rest7;
  logic [3:0]  e7, e_cnt, mon;

  // Stage 1: Gregorian test and the numerator for alpha.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      jn1 <= day_number;
      gr1 <= (day_number >= cdn_pkg::GREG_JDN);
      xa1 <= 25'({day_number, 2'b00}) - 25'd7468865;
    end
  end

  // Stage 2: reciprocal product for alpha = (4z - 7468865) / 146097.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      jn2 <= jn1;
      gr2 <= gr1;
      pa2 <= 51'(xa1) * 51'(cdn_pkg::AL_MUL);
    end
  end

  // Stage 3: century correction gives b.
  assign alpha = 8'(pa2 >> cdn_pkg::AL_SHIFT);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (gr2) begin
        b3 <= jn2 + 23'd1525 + 23'(alpha) - 23'(alpha[7:2]);
      end else begin
        b3 <= jn2 + 23'd1524;
      end
    end
  end

  // Stage 4: numerator of the year count c.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      b4  <= b3;
      xc4 <= 30'(b3) * 30'd100 - 30'd12210;
    end
  end

  // Stage 5: reciprocal product for c = xc / 36525.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      b5  <= b4;
      pc5 <= 61'(xc4) * 61'(cdn_pkg::C_MUL);
    end
  end

  // Stage 6: days left after the whole years.
  assign c_cur = 15'(pc5 >> cdn_pkg::C_SHIFT);
  assign dd6   = 26'(c_cur) * 26'd1461;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      c6    <= c_cur;
      rest6 <= 10'(b5 - 23'(dd6[25:2]));
    end
  end

  // Stage 7: month index e is the count of month starts that rest passes.
  always_comb begin
    e_cnt = '0;
    for (int k = 1; k < 16; k++) begin
      if (rest6 > 10'(cdn_pkg::E_DAYS[4'(k)])) begin
        e_cnt = e_cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      c7    <= c6;
      rest7 <= rest6;
      e7    <= e_cnt;
    end
  end

  // Stage 8: day, month and year of the date.
  assign mon = (e7 < 4'd14) ? e7 - 4'd1 : e7 - 4'd13;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      day   <= 5'(rest7 - 10'(cdn_pkg::E_DAYS[e7]));
      month <= mon;
      year  <= (mon > 4'd2) ? 14'(c7 - 15'd4716) : 14'(c7 - 15'd4715);
    end
  end

endmodule

// ----- design/calendar_day_number_converter.sv -----
// Calendar day number converter: civil date <-> Julian day number, ten-stage pipeline.
// Items pass stages 1 to 10, the last holding the result; while rsp_ready is high, throughput
// is one item per cycle, set by the stage pitch, the widest stage being a 30 x 31 bit multiply.
// Each stage advances when it is empty or its successor advances, so bubbles close up.
// Reset clears the stage valid bits only; the block is ready in the cycle after reset.
`include "assert_macros.svh"

module calendar_day_number_converter (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cdn_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cdn_pkg::rsp_t  rsp
);

  logic [cdn_pkg::STAGES:1] vld;
  logic [cdn_pkg::STAGES:1] en;
  cdn_pkg::pipe_t           pipe [1:cdn_pkg::STAGES-1];
  cdn_pkg::pipe_t           pipe3_next, pipe5_next, pipe9_next;

  // Date path intermediates.
  logic [13:0] yy1;
  logic [3:0]  mm1;
  logic        greg1, greg2;
  logic [25:0] py2;
  logic [7:0]  a2;
  logic [8:0]  t2;
  logic [24:0] dj;
  logic [48:0] pw4;
  logic [7:0]  q100_9;

  // Split path results and merge.
  logic [4:0]  sp_day;
  logic [3:0]  sp_month;
  logic [13:0] sp_year;
  logic [13:0] ysel;

  // Final stage logic.
  logic          leap, date_ok, gap, ok;
  logic [9:0]    yday;
  cdn_pkg::rsp_t rsp_next;
  logic          rsp_sane;

  // Stage enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    en[cdn_pkg::STAGES] = !vld[cdn_pkg::STAGES] || rsp_ready;
    for (int k = cdn_pkg::STAGES - 1; k >= 1; k--) begin
      en[4'(k)] = !vld[4'(k)] || en[4'(k + 1)];
    end
  end

  assign req_ready = en[1];
  assign rsp_valid = vld[cdn_pkg::STAGES];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= req_valid;
      end
      for (int k = 2; k <= cdn_pkg::STAGES; k++) begin
        if (en[4'(k)]) begin
          vld[4'(k)] <= vld[4'(k - 1)];
        end
      end
    end
  end

  // Stage 1: capture the transfer, shift January and February to the prior year.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pipe[1].op  <= req.opcode;
      pipe[1].rng <= (req.day_number >= cdn_pkg::JDN_MIN) &&
                     (req.day_number <= cdn_pkg::JDN_MAX);
      pipe[1].d   <= req.day;
      pipe[1].m   <= req.month;
      pipe[1].y   <= req.year;
      pipe[1].jn  <= req.day_number;
      pipe[1].wd  <= '0;
      yy1   <= (req.month < 4'd3) ? req.year - 14'd1 : req.year;
      mm1   <= (req.month < 4'd3) ? req.month + 4'd12 : req.month;
      greg1 <= ({req.year, req.month, req.day} >= cdn_pkg::GREG_KEY);
    end
  end

  // Stage 2: year and month terms of the day number.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pipe[2] <= pipe[1];
      greg2   <= greg1;
      py2     <= 26'(15'(yy1) + 15'd4716) * 26'd1461;
      a2      <= cdn_pkg::div100(yy1);
      t2      <= cdn_pkg::E_DAYS[4'(mm1 + 4'd1)];
    end
  end

  // Stage 3: sum the terms; the Gregorian side adds the century correction.
  always_comb begin
    dj = 25'(py2[25:2]) + 25'(t2) + 25'(pipe[2].d) - 25'd1524;
    if (greg2) begin
      dj = dj + 25'd2 + 25'(a2[7:2]) - 25'(a2);
    end
    pipe3_next = pipe[2];
    if (pipe[2].op == cdn_pkg::OP_DATE_TO_JDN) begin
      pipe3_next.jn = dj[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pipe[3] <= pipe3_next;
    end
  end

  // Stage 4: reciprocal product for (jn + 1) / 7.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pipe[4] <= pipe[3];
      pw4     <= 49'(24'(pipe[3].jn) + 24'd1) * 49'(cdn_pkg::WK_MUL);
    end
  end

  // Stage 5: weekday is (jn + 1) - 7q, which only needs the low three bits.
  always_comb begin
    pipe5_next    = pipe[4];
    pipe5_next.wd = pipe[4].jn[2:0] + 3'd1 + 3'(pw4 >> cdn_pkg::WK_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pipe[5] <= pipe5_next;
    end
  end

  // Stages 6 to 8 carry the item while the date is worked out.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      pipe[6] <= pipe[5];
    end
    if (en[7]) begin
      pipe[7] <= pipe[6];
    end
    if (en[8]) begin
      pipe[8] <= pipe[7];
    end
  end

  cdn_jdn_to_date u_split (
    .clk        (clk),
    .en         (en[cdn_pkg::SPLIT_STAGES:1]),
    .day_number (req.day_number),
    .day        (sp_day),
    .month      (sp_month),
    .year       (sp_year)
  );

  // Stage 9: pick the date by direction and start the century test of the year.
  assign ysel = (pipe[8].op == cdn_pkg::OP_JDN_TO_DATE) ? sp_year : pipe[8].y;

  always_comb begin
    pipe9_next = pipe[8];
    if (pipe[8].op == cdn_pkg::OP_JDN_TO_DATE) begin
      pipe9_next.d = sp_day;
      pipe9_next.m = sp_month;
      pipe9_next.y = sp_year;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      pipe[9] <= pipe9_next;
      q100_9  <= cdn_pkg::div100(ysel);
    end
  end

  // Stage 10: leap year, date check, day of year and the result register.
  always_comb begin
    if (pipe[9].y[1:0] != 2'd0) begin
      leap = 1'b0;
    end else if (pipe[9].y < 14'd1582) begin
      leap = 1'b1;
    end else if (pipe[9].y != 14'(q100_9) * 14'd100) begin
      leap = 1'b1;
    end else begin
      leap = (q100_9[1:0] == 2'd0);
    end

    gap = (pipe[9].y == 14'd1582) && (pipe[9].m == 4'd10) &&
          (pipe[9].d inside {[5'd5:5'd14]});
    if ((pipe[9].y inside {[14'd1:14'd9999]}) && (pipe[9].m inside {[4'd1:4'd12]})) begin
      if ((pipe[9].m == 4'd2) && (pipe[9].d == 5'd29)) begin
        date_ok = leap;
      end else begin
        date_ok = !gap && (pipe[9].d != 5'd0) &&
                  (pipe[9].d <= cdn_pkg::MONTH_DAYS[pipe[9].m]);
      end
    end else begin
      date_ok = 1'b0;
    end
    ok = (pipe[9].op == cdn_pkg::OP_JDN_TO_DATE) ? pipe[9].rng : date_ok;

    yday = 10'(cdn_pkg::ORD_DAYS[pipe[9].m]) + 10'(pipe[9].d) - 10'd30;
    if (pipe[9].m >= 4'd3) begin
      yday = yday - (leap ? 10'd1 : 10'd2);
    end

    rsp_next = '0;
    if (ok) begin
      rsp_next.ok             = 1'b1;
      rsp_next.out_day_number = pipe[9].jn;
      rsp_next.out_day        = pipe[9].d;
      rsp_next.out_month      = pipe[9].m;
      rsp_next.out_year       = pipe[9].y;
      rsp_next.weekday        = pipe[9].wd;
      rsp_next.year_day       = yday[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[cdn_pkg::STAGES]) begin
      rsp <= rsp_next;
    end
  end

  // Field ranges that every good result must meet.
  always_comb begin
    rsp_sane = (rsp.out_month >= 4'd1) && (rsp.out_month <= 4'd12) &&
               (rsp.out_day >= 5'd1) && (rsp.weekday <= 3'd6) &&
               (rsp.year_day >= 9'd1) && (rsp.year_day <= 9'd366) &&
               (rsp.out_day_number >= cdn_pkg::JDN_MIN) &&
               (rsp.out_day_number <= cdn_pkg::JDN_MAX);
  end

  `ASSERT_CLK(a_rst_empty, $past(rst) |-> !rsp_valid, "result valid right after reset")
  `ASSERT_CLK(a_stall_full, !req_ready |-> (&vld), "input stalled with a stage empty")
  `ASSERT_CLK(a_ok_sane, rsp_valid && rsp.ok |-> rsp_sane, "good result out of range")
  `ASSERT_CLK(a_bad_zero, rsp_valid && !rsp.ok |-> (rsp == '0), "failed result not cleared")

endmodule

// ----- verif/tb_calendar_day_number_converter.sv -----
// Self-checking testbench for the calendar day number converter.
// Predicts each result from the request alone; depends on cdn_pkg and the converter RTL.
module tb_calendar_day_number_converter;

  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 170;
  localparam int SPECIAL_YEARS [10] = '{1, 4, 100, 1500, 1581, 1582, 1600, 1700, 2000, 9999};

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  cdn_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  cdn_pkg::rsp_t rsp;

  // Chance in a hundred that the sender idles or the receiver stalls in a cycle.
  int            send_idle_pct;
  int            recv_stall_pct;
  int            wrong_results;
  cdn_pkg::rsp_t pending_conversions [$];
  cdn_pkg::rsp_t oldest_conversion;

  calendar_day_number_converter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous limit on the whole run.
  initial begin
    #3200000;
    $display("calendar_day_number_converter: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Conversion predictor
  // ---------------------------------------------------------------------------

  // Julian rule before 1582, Gregorian rule from 1582 on.
  function automatic bit leap_year(input longint unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y < 1582) return 1'b1;
    if (y % 100 != 0) return 1'b1;
    if (y % 400 != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint unsigned month_length(input longint unsigned m,
                                                   input longint unsigned y);
    case (m)
      2: begin
        return 28 + leap_year(y);
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // A date is valid inside years 1..9999 and outside the ten skipped days of 1582.
  function automatic bit civil_date_valid(input longint unsigned d, input longint unsigned m,
                                          input longint unsigned y);
    if (y < 1 || y > 9999) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    if (d < 1 || d > month_length(m, y)) return 1'b0;
    if (y == 1582 && m == 10 && d > 4 && d < 15) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint unsigned civil_to_jdn(input longint unsigned d,
                                                   input longint unsigned m,
                                                   input longint unsigned y);
    logic [22:0]     date_key;
    longint unsigned yy;
    longint unsigned mm;
    longint unsigned j;
    longint unsigned cent;
    date_key = {y[13:0], m[3:0], d[4:0]};
    yy = y;
    mm = m;
    // January and February count as months 13 and 14 of the previous year.
    if (mm < 3) begin
      yy = yy - 1;
      mm = mm + 12;
    end
    j = (1461 * (yy + 4716)) / 4 + (306 * (mm + 1)) / 10 + d;
    if (date_key >= cdn_pkg::GREG_KEY) begin
      cent = yy / 100;
      j = j + 2 + cent / 4 - cent;
    end
    return j - 1524;
  endfunction

  function automatic void jdn_to_civil(input longint unsigned z, output longint unsigned d,
                                       output longint unsigned m, output longint unsigned y);
    longint unsigned alpha;
    longint unsigned b;
    longint unsigned c;
    longint unsigned rest;
    longint unsigned e;
    // Gregorian days get the century correction first.
    if (z >= cdn_pkg::GREG_JDN) begin
      alpha = (4 * z - 7468865) / 146097;
      z = z + 1 + alpha - alpha / 4;
    end
    b = z + 1524;
    c = (100 * b - 12210) / 36525;
    rest = b - (1461 * c) / 4;
    e = (10000 * rest) / 306001;
    d = rest - (306001 * e) / 10000;
    m = (e < 14) ? e - 1 : e - 13;
    y = (m > 2) ? c - 4716 : c - 4715;
  endfunction

  // Full result of one request; an invalid request gives an all-zero result.
  function automatic cdn_pkg::rsp_t expected_conversion(input cdn_pkg::req_t r);
    cdn_pkg::rsp_t   res;
    longint unsigned d;
    longint unsigned m;
    longint unsigned y;
    longint unsigned jn;
    longint unsigned leap_adj;
    bit              valid;
    res = '0;
    d = r.day;
    m = r.month;
    y = r.year;
    jn = r.day_number;
    if (r.opcode == cdn_pkg::OP_DATE_TO_JDN) begin
      valid = civil_date_valid(d, m, y);
      if (valid) jn = civil_to_jdn(d, m, y);
    end else begin
      valid = (jn >= cdn_pkg::JDN_MIN && jn <= cdn_pkg::JDN_MAX);
      if (valid) jdn_to_civil(jn, d, m, y);
    end
    if (valid) begin
      // The day of the year ignores the skipped October days of 1582.
      leap_adj = (2 - leap_year(y)) * ((m + 9) / 12);
      res.ok             = 1'b1;
      res.out_day_number = jn[22:0];
      res.out_day        = d[4:0];
      res.out_month      = m[3:0];
      res.out_year       = y[13:0];
      res.weekday        = 3'((jn + 1) % 7);
      res.year_day       = 9'((275 * m) / 9 + d - 30 - leap_adj);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic string result_text(input cdn_pkg::rsp_t x);
    return $sformatf("ok=%0d jdn=%0d date=%0d-%0d-%0d wd=%0d yday=%0d", x.ok,
                     x.out_day_number, x.out_year, x.out_month, x.out_day, x.weekday,
                     x.year_day);
  endfunction

  task automatic note_error(input string msg);
    wrong_results++;
    if (wrong_results <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_conversions.size() == 0) begin
          note_error($sformatf("unexpected result at %0t: %s", $realtime, result_text(rsp)));
        end else begin
          oldest_conversion = pending_conversions.pop_front();
          if (rsp.ok !== oldest_conversion.ok ||
              rsp.out_day_number !== oldest_conversion.out_day_number ||
              rsp.out_day !== oldest_conversion.out_day ||
              rsp.out_month !== oldest_conversion.out_month ||
              rsp.out_year !== oldest_conversion.out_year ||
              rsp.weekday !== oldest_conversion.weekday ||
              rsp.year_day !== oldest_conversion.year_day) begin
            note_error($sformatf("wrong result at %0t: expected %s, got %s", $realtime,
                                 result_text(oldest_conversion), result_text(rsp)));
          end
        end
      end
      if (req_valid && req_ready) pending_conversions.push_back(expected_conversion(req));
    end
  end

  // Receiver: ready is redrawn at every falling edge.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the transfer,
  // after any idle cycles that the sender draws.
  task automatic send_request(input cdn_pkg::req_t r);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_for_results;
    req_valid <= 1'b0;
    while (pending_conversions.size() != 0) @(negedge clk);
  endtask

  function automatic cdn_pkg::req_t date_request(input int d, input int m, input int y);
    cdn_pkg::req_t r;
    r = '0;
    r.opcode = cdn_pkg::OP_DATE_TO_JDN;
    r.day    = 5'(d);
    r.month  = 4'(m);
    r.year   = 14'(y);
    return r;
  endfunction

  function automatic cdn_pkg::req_t jdn_request(input logic [22:0] n);
    cdn_pkg::req_t r;
    r = '0;
    r.opcode     = cdn_pkg::OP_JDN_TO_DATE;
    r.day_number = n;
    return r;
  endfunction

  // Mostly well-formed dates and in-range day numbers, the rest raw field values.
  function automatic cdn_pkg::req_t random_request;
    cdn_pkg::req_t r;
    int            sel;
    int            y;
    int            m;
    r.opcode     = 1'($urandom);
    r.day        = 5'($urandom);
    r.month      = 4'($urandom);
    r.year       = 14'($urandom);
    r.day_number = 23'($urandom);
    sel = $urandom_range(99);
    if (r.opcode == cdn_pkg::OP_DATE_TO_JDN) begin
      if (sel < 60) begin
        y = (sel < 15) ? SPECIAL_YEARS[$urandom_range(9)] : $urandom_range(9999, 1);
        m = $urandom_range(12, 1);
        r.year  = 14'(y);
        r.month = 4'(m);
        r.day   = 5'($urandom_range(month_length(m, y), 1));
      end else if (sel < 75) begin
        // Around the calendar switch, any day number of the month field.
        r.year  = 14'($urandom_range(1583, 1581));
        r.month = 4'($urandom_range(12, 9));
        r.day   = 5'($urandom_range(31, 1));
      end
    end else begin
      if (sel < 50) begin
        r.day_number = 23'($urandom_range(cdn_pkg::JDN_MAX, cdn_pkg::JDN_MIN));
      end else if (sel < 75) begin
        r.day_number = 23'($urandom_range(cdn_pkg::GREG_JDN + 800, cdn_pkg::GREG_JDN - 800));
      end else if (sel < 85) begin
        r.day_number = (sel < 80) ? 23'(cdn_pkg::JDN_MIN + $urandom_range(400)) :
                                    23'(cdn_pkg::JDN_MAX - $urandom_range(400));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_date_field_limits;
    send_request(date_request(1, 1, 1));
    send_request(date_request(31, 12, 9999));
    send_request(date_request(1, 1, 0));
    send_request(date_request(31, 15, 16383));
    send_request(date_request(0, 6, 2024));
    send_request(date_request(31, 6, 2024));
    send_request(date_request(31, 1, 2024));
    send_request(date_request(10, 0, 2024));
    send_request(date_request(10, 13, 2024));
  endtask

  task automatic test_leap_years_and_gap;
    send_request(date_request(29, 2, 4));
    send_request(date_request(29, 2, 1500));
    send_request(date_request(29, 2, 1600));
    send_request(date_request(29, 2, 1700));
    send_request(date_request(29, 2, 1900));
    send_request(date_request(31, 12, 2000));
    send_request(date_request(4, 10, 1582));
    send_request(date_request(5, 10, 1582));
    send_request(date_request(14, 10, 1582));
    send_request(date_request(15, 10, 1582));
  endtask

  task automatic test_day_number_limits;
    send_request(jdn_request(cdn_pkg::JDN_MIN));
    send_request(jdn_request(cdn_pkg::JDN_MAX));
    send_request(jdn_request(cdn_pkg::JDN_MIN - 23'd1));
    send_request(jdn_request(cdn_pkg::JDN_MAX + 23'd1));
    send_request(jdn_request('0));
    send_request(jdn_request('1));
    send_request(jdn_request(cdn_pkg::GREG_JDN - 23'd1));
    send_request(jdn_request(cdn_pkg::GREG_JDN));
  endtask

  // Random stream; halfway through the sender holds off until every result is back.
  task automatic test_random_stream(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_for_results();
      send_request(random_request());
    end
    wait_for_results();
  endtask

  // Main sequence.
  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wrong_results  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_date_field_limits();
    test_leap_years_and_gap();
    test_day_number_limits();
    wait_for_results();
    test_random_stream(0, 0);
    test_random_stream(83, 0);
    test_random_stream(0, 83);
    test_random_stream(23, 23);

    // Let any stray result surface before the verdict.
    recv_stall_pct = 0;
    repeat (3 * cdn_pkg::STAGES) @(negedge clk);
    if (wrong_results == 0 && pending_conversions.size() == 0) begin
      $display("calendar_day_number_converter: match");
    end else begin
      $display("calendar_day_number_converter: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cdn_pkg.sv
design/cdn_jdn_to_date.sv
design/calendar_day_number_converter.sv
verif/tb_calendar_day_number_converter.sv
